// ===== rtl/core/acpt_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types of the ascii coordinate pid tracker
// no dependencies

package acpt_pkg;

  // frame bytes
  localparam logic [7:0] BYTE_START = 8'h61;
  localparam logic [7:0] BYTE_END   = 8'h6B;
  localparam logic [7:0] BYTE_SEP   = 8'h20;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;

  // reset values
  localparam logic [7:0]         TARGET_X_RST       = 8'd120;
  localparam logic signed [15:0] GAIN_P_RST         = 16'sd410;
  localparam logic signed [15:0] GAIN_I_RST         = 16'sd0;
  localparam logic signed [15:0] GAIN_D_RST         = 16'sd0;
  localparam logic [9:0]         INTEGRAL_LIMIT_RST = 10'd50;
  localparam logic [7:0]         COORD_X_RST        = 8'd120;
  localparam logic [7:0]         COORD_Y_RST        = 8'd160;

  typedef struct packed {
    logic [7:0]         target_x;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic [9:0]         integral_limit;
  } cfg_t;

  // a completed frame handed from the parser to the control loop
  typedef struct packed {
    logic               valid;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic signed [31:0] yaw_angle;
  } frame_t;

endpackage

// ===== rtl/core/acpt_ifs.sv =====
`timescale 1ns / 1ps
// channel interfaces of the ascii coordinate pid tracker
// depends on acpt_pkg

interface acpt_item_if;
  logic               valid;
  logic               ready;
  logic [7:0]         rx_byte;
  logic signed [31:0] yaw_angle;
  modport source (output valid, rx_byte, yaw_angle, input ready);
  modport sink (input valid, rx_byte, yaw_angle, output ready);
endinterface

interface acpt_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] yaw_target;
  logic [7:0]         pos_x;
  logic [7:0]         pos_y;
  modport source (output valid, yaw_target, pos_x, pos_y, input ready);
  modport sink (input valid, yaw_target, pos_x, pos_y, output ready);
endinterface

interface acpt_cfg_if;
  import acpt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/acpt_parser.sv =====
`timescale 1ns / 1ps
// ascii frame parser: 'a' x ' ' y 'k', digits folded modulo 256
// depends on acpt_pkg

module acpt_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  logic [7:0]              rx_byte,
  input  logic signed [31:0]      yaw_angle,
  output acpt_pkg::frame_t        frame
);
  import acpt_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] accum, accum_next;
  logic [7:0] coord_x, coord_x_next;
  logic [7:0] coord_y, coord_y_next;
  logic       is_digit;
  logic [7:0] folded;
  logic       done;

  assign is_digit = (rx_byte >= BYTE_ZERO) && (rx_byte <= BYTE_NINE);
  // acc * 10 + digit, wrapping
  assign folded = (accum << 3) + (accum << 1) + {4'b0000, rx_byte[3:0]};

  always_comb begin
    phase_next   = phase;
    accum_next   = accum;
    coord_x_next = coord_x;
    coord_y_next = coord_y;
    done         = 1'b0;
    if (rx_byte == BYTE_START) begin
      // restart keeps leftover digits
      phase_next = PH_X;
    end else begin
      case (phase)
        PH_X: begin
          if (rx_byte == BYTE_SEP) begin
            phase_next   = PH_Y;
            coord_x_next = accum;
            accum_next   = 8'd0;
          end else if (!is_digit) begin
            phase_next = PH_IDLE;
            accum_next = 8'd0;
          end else begin
            accum_next = folded;
          end
        end
        PH_Y: begin
          if (rx_byte == BYTE_END) begin
            phase_next   = PH_IDLE;
            coord_y_next = accum;
            accum_next   = 8'd0;
            done         = 1'b1;
          end else if (!is_digit) begin
            phase_next = PH_IDLE;
            accum_next = 8'd0;
          end else begin
            accum_next = folded;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          accum_next = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      accum   <= 8'd0;
      coord_x <= COORD_X_RST;
      coord_y <= COORD_Y_RST;
    end else if (fire) begin
      phase   <= phase_next;
      accum   <= accum_next;
      coord_x <= coord_x_next;
      coord_y <= coord_y_next;
    end
  end

  assign frame.valid     = fire && done;
  assign frame.pos_x     = coord_x;
  assign frame.pos_y     = accum;
  assign frame.yaw_angle = yaw_angle;

endmodule

// ===== rtl/core/acpt_pid.sv =====
`timescale 1ns / 1ps
// pid step on x: error and integral, products, sum and saturating subtract
// depends on acpt_pkg and acpt_ifs

module acpt_pid (
  input  logic             clk,
  input  logic             rst,
  input  acpt_pkg::cfg_t   cfg,
  input  acpt_pkg::frame_t frame,
  output logic             frame_ready,
  acpt_result_if.source    result
);
  import acpt_pkg::*;

  // loop state
  logic signed [10:0] integral;
  logic signed [8:0]  prev_err;

  // stage 1: error terms
  logic               v1;
  logic signed [8:0]  s1_err;
  logic signed [9:0]  s1_derr;
  logic signed [10:0] s1_int;
  logic signed [31:0] s1_yaw;
  logic [7:0]         s1_x;
  logic [7:0]         s1_y;

  // stage 2: products
  logic               v2;
  logic signed [24:0] s2_p;
  logic signed [25:0] s2_d;
  logic signed [26:0] s2_i;
  logic signed [31:0] s2_yaw;
  logic [7:0]         s2_x;
  logic [7:0]         s2_y;

  logic               rdy1, rdy2, rdy3;

  logic signed [8:0]  err_next;
  logic signed [11:0] sum_next;
  logic signed [11:0] lim;
  logic signed [10:0] integral_next;
  logic signed [9:0]  derr_next;
  logic signed [24:0] p_next;
  logic signed [25:0] d_next;
  logic signed [26:0] i_next;
  logic signed [28:0] corr;
  logic signed [33:0] diff;
  logic signed [31:0] sat;

  assign rdy3 = !result.valid || result.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign frame_ready = rdy1;

  always_comb begin
    err_next  = $signed({1'b0, cfg.target_x}) - $signed({1'b0, frame.pos_x});
    sum_next  = integral + err_next;
    lim       = $signed({2'b00, cfg.integral_limit});
    if (sum_next > lim) begin
      integral_next = lim[10:0];
    end else if (sum_next < -lim) begin
      integral_next = 11'(-lim);
    end else begin
      integral_next = sum_next[10:0];
    end
    derr_next = err_next - prev_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      prev_err <= '0;
      v1       <= 1'b0;
    end else begin
      if (frame.valid) begin
        integral <= integral_next;
        prev_err <= err_next;
      end
      if (rdy1) begin
        v1 <= frame.valid;
      end
    end
    if (rdy1 && frame.valid) begin
      s1_err  <= err_next;
      s1_derr <= derr_next;
      s1_int  <= integral_next;
      s1_yaw  <= frame.yaw_angle;
      s1_x    <= frame.pos_x;
      s1_y    <= frame.pos_y;
    end
  end

  assign p_next = cfg.gain_p * s1_err;
  assign d_next = cfg.gain_d * s1_derr;
  assign i_next = cfg.gain_i * s1_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      s2_p   <= p_next;
      s2_d   <= d_next;
      s2_i   <= i_next;
      s2_yaw <= s1_yaw;
      s2_x   <= s1_x;
      s2_y   <= s1_y;
    end
  end

  // q4.12 gains give a correction with 12 fraction bits; times 16 gives q16.16
  always_comb begin
    corr = s2_p + s2_d + s2_i;
    diff = s2_yaw - $signed({corr, 4'b0000});
    if (!diff[33] && (diff[32:31] != 2'b00)) begin
      sat = 32'sh7FFF_FFFF;
    end else if (diff[33] && (diff[32:31] != 2'b11)) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (rdy3) begin
      result.valid <= v2;
    end
    if (rdy3 && v2) begin
      result.yaw_target <= sat;
      result.pos_x      <= s2_x;
      result.pos_y      <= s2_y;
    end
  end

endmodule

// ===== rtl/core/ascii_coordinate_pid_tracker.sv =====
`timescale 1ns / 1ps
// top level: configuration registers, frame parser and pid pipeline
// depends on acpt_pkg, acpt_ifs, acpt_parser and acpt_pid

// Takes one received byte with the current yaw per transfer on item and emits
// one result on the byte 'k' that closes a frame 'a' x ' ' y 'k'. A byte
// can be taken in every cycle while item.ready is high; the result of a closing
// byte is registered in turn by the three pipeline registers of the pid
// step (error and integral, products, sum with saturation). item.ready only
// drops when all three stages hold results and result is stalled.
// Configuration writes on cfg are taken in every cycle and belong to idle
// periods.

module ascii_coordinate_pid_tracker (
  input logic           clk,
  input logic           rst,
  acpt_item_if.sink     item,
  acpt_result_if.source result,
  acpt_cfg_if.sink      cfg
);
  import acpt_pkg::*;

  cfg_t   regs;
  frame_t frame;
  logic   fire;
  logic   pid_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.target_x       <= TARGET_X_RST;
      regs.gain_p         <= GAIN_P_RST;
      regs.gain_i         <= GAIN_I_RST;
      regs.gain_d         <= GAIN_D_RST;
      regs.integral_limit <= INTEGRAL_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_TARGET_X:       regs.target_x       <= cfg.data[7:0];
        CFG_GAIN_P:         regs.gain_p         <= $signed(cfg.data);
        CFG_GAIN_I:         regs.gain_i         <= $signed(cfg.data);
        CFG_GAIN_D:         regs.gain_d         <= $signed(cfg.data);
        CFG_INTEGRAL_LIMIT: regs.integral_limit <= cfg.data[9:0];
        default: begin
        end
      endcase
    end
  end

  assign item.ready = pid_ready;
  assign fire       = item.valid && pid_ready;

  acpt_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (item.rx_byte),
    .yaw_angle (item.yaw_angle),
    .frame     (frame)
  );

  acpt_pid u_pid (
    .clk         (clk),
    .rst         (rst),
    .cfg         (regs),
    .frame       (frame),
    .frame_ready (pid_ready),
    .result      (result)
  );

`ifndef SYNTH
  // a frame only completes on a transfer of the closing byte
  a_frame_on_end: assert property (@(posedge clk) disable iff (rst)
    frame.valid |-> (fire && (item.rx_byte == BYTE_END)))
    else $error("frame completed without a closing byte transfer");

  // input back-pressure only comes from a full pipeline behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (result.valid && !result.ready))
    else $error("input stalled while result side is free");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule
